[src/indexed_min_heap_priority_queue_top_assert.svh]
// assertion helpers for the heap queue top level
`ifndef INDEXED_MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define INDEXED_MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, checked on i_clk outside reset
`define IMHPQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk outside reset
`define IMHPQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/imhpq_pkg.sv]
package imhpq_pkg;

    localparam int OP_W = 2;
    localparam int ST_W = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_CHECK,
        S_LAST,
        S_DOWN,
        S_UP,
        S_DONE
    } t_state;

    // broadcast strobes to the level cells
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_cell_ctl;

endpackage

[src/imhpq_level_cell.sv]
module imhpq_level_cell #(
    parameter int LEVEL       = 0,
    parameter int WEIGHT_BITS = 32,
    parameter int ID_W        = 6,
    parameter int NODE_W      = 7,
    parameter int LVL_W       = 3
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  imhpq_pkg::t_cell_ctl             i_ctl,
    input  logic [LVL_W-1:0]                 i_rd_lvl,
    input  logic [NODE_W-1:0]                i_rd_node,
    input  logic [LVL_W-1:0]                 i_wr_lvl,
    input  logic [NODE_W-1:0]                i_wr_node,
    input  logic [WEIGHT_BITS+ID_W-1:0]      i_wr_entry,
    input  logic [2*(WEIGHT_BITS+ID_W)-1:0]  i_chain,
    output logic [2*(WEIGHT_BITS+ID_W)-1:0]  o_chain
);

    localparam int EW   = WEIGHT_BITS + ID_W;
    localparam int RW   = (LEVEL > 1) ? LEVEL - 1 : 1;
    localparam int ROWS = 1 << RW;

    // one row holds a sibling pair: even node in the low half, odd node in the high half
    logic [EW-1:0] r_mem_lo [ROWS];
    logic [EW-1:0] r_mem_hi [ROWS];
    logic [EW-1:0] r_rd_lo;
    logic [EW-1:0] r_rd_hi;
    logic          r_rd_hit;

    logic          rd_sel;
    logic          wr_sel;
    logic [RW-1:0] rd_row;
    logic [RW-1:0] wr_row;

    assign rd_sel = i_ctl.rd_en && (i_rd_lvl == LVL_W'(LEVEL));
    assign wr_sel = i_ctl.wr_en && (i_wr_lvl == LVL_W'(LEVEL));
    assign rd_row = i_rd_node[RW:1];
    assign wr_row = i_wr_node[RW:1];

    always_ff @(posedge i_clk) begin
        if (wr_sel) begin
            if (i_wr_node[0]) begin
                r_mem_hi[wr_row] <= i_wr_entry;
            end else begin
                r_mem_lo[wr_row] <= i_wr_entry;
            end
        end
        if (rd_sel) begin
            r_rd_lo <= r_mem_lo[rd_row];
            r_rd_hi <= r_mem_hi[rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_hit <= 1'b0;
        end else begin
            r_rd_hit <= rd_sel;
        end
    end

    // read data walks up the row toward level zero
    assign o_chain = r_rd_hit ? {r_rd_hi, r_rd_lo} : i_chain;

endmodule

[src/imhpq_pos_table.sv]
module imhpq_pos_table #(
    parameter int HANDLE_COUNT = 64,
    parameter int ID_W         = 6,
    parameter int SLOT_W       = 5
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ID_W-1:0]   i_rd_id,
    input  logic              i_wr_en,
    input  logic [ID_W-1:0]   i_wr_id,
    input  logic [SLOT_W-1:0] i_wr_slot,
    output logic [SLOT_W-1:0] o_rd_slot
);

    logic [SLOT_W-1:0] r_mem [HANDLE_COUNT];
    logic [SLOT_W-1:0] r_rd_slot;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_id] <= i_wr_slot;
        end
        if (i_rd_en) begin
            r_rd_slot <= r_mem[i_rd_id];
        end
    end

    assign o_rd_slot = r_rd_slot;

endmodule

[src/indexed_min_heap_priority_queue_top.sv]
// channel   dir  handshake                    payload
// s         in   i_s_tvalid / o_s_tready      i_s_tdata, i_s_tuser
// m         out  o_m_tvalid / i_m_tready      o_m_tdata, o_m_tuser
//
// one item at a time: accept, position lookup, slot check, then a sift walks the heap
// level by level (after a fetch of the last entry on a remove) and the result is posted;
// a query or a rejected item skips the sift and goes straight to the result post; each
// sift step is bounded by the single read port of each level cell.
// synchronous active-low reset empties the heap; stale position entries are
// screened by checking the slot's stored handle, so no clearing pass is needed.
// a stalled output holds the result register; the next item is still taken but waits in S_DONE.
`include "indexed_min_heap_priority_queue_top_assert.svh"

module indexed_min_heap_priority_queue_top #(
    parameter int CAPACITY     = 32,
    parameter int HANDLE_COUNT = 64,
    parameter int WEIGHT_BITS  = 32,
    localparam int ID_W        = $clog2(HANDLE_COUNT),
    localparam int CNT_W       = $clog2(CAPACITY + 1),
    localparam int S_TDATA_W   = ((ID_W + WEIGHT_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W   = ((1 + ID_W + 2 * WEIGHT_BITS + CNT_W + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [S_TDATA_W-1:0]        i_s_tdata,  // node_id, weight
    input  logic [imhpq_pkg::OP_W-1:0]  i_s_tuser,  // opcode
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // front_valid, front_id, front_weight, node_weight, entry_count
    output logic [M_TDATA_W-1:0]        o_m_tdata,
    output logic [imhpq_pkg::ST_W-1:0]  o_m_tuser   // status
);

    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int NODE_W  = CNT_W + 1;
    localparam int NL      = CNT_W;
    localparam int LVL_W   = $clog2(NL + 2);
    localparam int EW      = WEIGHT_BITS + ID_W;
    localparam int CHAIN_W = 2 * EW;

    function automatic logic [LVL_W-1:0] lvl_of(input logic [NODE_W-1:0] m);
        logic [LVL_W-1:0] lv;
        lv = '0;
        for (int b = 0; b < NODE_W; b++) begin
            if (m[b]) begin
                lv = LVL_W'(b);
            end
        end
        return lv;
    endfunction

    imhpq_pkg::t_state r_state, n_state;

    logic [imhpq_pkg::OP_W-1:0] r_op, n_op;
    logic [ID_W-1:0]            r_id, n_id;
    logic [WEIGHT_BITS-1:0]     r_w, n_w;
    logic [WEIGHT_BITS-1:0]     r_mw, n_mw;
    logic [ID_W-1:0]            r_mh, n_mh;
    logic [NODE_W-1:0]          r_n, n_n;
    logic [LVL_W-1:0]           r_lvl, n_lvl;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic [imhpq_pkg::ST_W-1:0] r_status, n_status;
    logic [WEIGHT_BITS-1:0]     r_nodew, n_nodew;
    logic                       r_first, n_first;
    logic [WEIGHT_BITS-1:0]     r_root_w, n_root_w;
    logic [ID_W-1:0]            r_root_h, n_root_h;

    logic                       r_out_valid;
    logic [imhpq_pkg::ST_W-1:0] r_o_status;
    logic                       r_o_fvalid;
    logic [ID_W-1:0]            r_o_fid;
    logic [WEIGHT_BITS-1:0]     r_o_fw;
    logic [WEIGHT_BITS-1:0]     r_o_nw;
    logic [CNT_W-1:0]           r_o_cnt;
    logic                       out_load;

    imhpq_pkg::t_cell_ctl       cell_ctl;
    logic [LVL_W-1:0]           cell_rd_lvl;
    logic [NODE_W-1:0]          cell_rd_node;
    logic [LVL_W-1:0]           cell_wr_lvl;
    logic [NODE_W-1:0]          cell_wr_node;
    logic [EW-1:0]              cell_wr_entry;
    logic [CHAIN_W-1:0]         w_chain [NL+1];

    logic                       pos_rd_en;
    logic [ID_W-1:0]            pos_rd_id;
    logic                       pos_wr_en;
    logic [ID_W-1:0]            pos_wr_id;
    logic [SLOT_W-1:0]          pos_wr_slot;
    logic [SLOT_W-1:0]          pos_rd_slot;

    logic                       s_acc;
    logic [EW-1:0]              rd_lo, rd_hi, sel_ent;
    logic                       sel_par;
    logic [WEIGHT_BITS-1:0]     sel_w;
    logic [ID_W-1:0]            sel_h;
    logic                       id_ok;
    logic                       present;
    logic [NODE_W-1:0]          cnt_ext;
    logic [NODE_W-1:0]          kid_l, kid_r, kid;
    logic                       l_ok, r_ok, pick_l, pick_r;
    logic [WEIGHT_BITS-1:0]     best_w;
    logic [EW-1:0]              kid_ent;
    logic [NODE_W-1:0]          ins_node;
    logic [NODE_W-1:0]          look_node;

    // level cells, one per heap level
    assign w_chain[NL] = '0;

    for (genvar k = 0; k < NL; k++) begin : g_lvl
        imhpq_level_cell #(
            .LEVEL       (k),
            .WEIGHT_BITS (WEIGHT_BITS),
            .ID_W        (ID_W),
            .NODE_W      (NODE_W),
            .LVL_W       (LVL_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl),
            .i_rd_lvl   (cell_rd_lvl),
            .i_rd_node  (cell_rd_node),
            .i_wr_lvl   (cell_wr_lvl),
            .i_wr_node  (cell_wr_node),
            .i_wr_entry (cell_wr_entry),
            .i_chain    (w_chain[k+1]),
            .o_chain    (w_chain[k])
        );
    end

    imhpq_pos_table #(
        .HANDLE_COUNT (HANDLE_COUNT),
        .ID_W         (ID_W),
        .SLOT_W       (SLOT_W)
    ) u_pos (
        .i_clk     (i_clk),
        .i_rd_en   (pos_rd_en),
        .i_rd_id   (pos_rd_id),
        .i_wr_en   (pos_wr_en),
        .i_wr_id   (pos_wr_id),
        .i_wr_slot (pos_wr_slot),
        .o_rd_slot (pos_rd_slot)
    );

    assign o_s_tready = (r_state == imhpq_pkg::S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;

    assign rd_lo = w_chain[0][EW-1:0];
    assign rd_hi = w_chain[0][CHAIN_W-1:EW];

    always_comb begin
        case (r_state)
            imhpq_pkg::S_CHECK: sel_par = r_n[0];
            imhpq_pkg::S_LAST:  sel_par = ~r_cnt[0];
            default:            sel_par = r_n[1];
        endcase
    end

    assign sel_ent = sel_par ? rd_hi : rd_lo;
    assign sel_w   = sel_ent[WEIGHT_BITS-1:0];
    assign sel_h   = sel_ent[EW-1:WEIGHT_BITS];

    assign cnt_ext = {1'b0, r_cnt};
    assign id_ok   = {1'b0, r_id} < (ID_W + 1)'(HANDLE_COUNT);
    // present means the handle is in range, the slot is in use and still carries this handle
    assign present = id_ok && (r_n <= cnt_ext) && (sel_h == r_id);

    assign kid_l   = {r_n[NODE_W-2:0], 1'b0};
    assign kid_r   = {r_n[NODE_W-2:0], 1'b1};
    assign l_ok    = kid_l <= cnt_ext;
    assign r_ok    = kid_r <= cnt_ext;
    assign pick_l  = l_ok && (rd_lo[WEIGHT_BITS-1:0] < r_mw);
    assign best_w  = pick_l ? rd_lo[WEIGHT_BITS-1:0] : r_mw;
    assign pick_r  = r_ok && (rd_hi[WEIGHT_BITS-1:0] < best_w);
    assign kid     = pick_r ? kid_r : kid_l;
    assign kid_ent = pick_r ? rd_hi : rd_lo;

    assign ins_node  = cnt_ext + NODE_W'(1);
    assign look_node = NODE_W'(pos_rd_slot) + NODE_W'(1);

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_id     = r_id;
        n_w      = r_w;
        n_mw     = r_mw;
        n_mh     = r_mh;
        n_n      = r_n;
        n_lvl    = r_lvl;
        n_cnt    = r_cnt;
        n_status = r_status;
        n_nodew  = r_nodew;
        n_first  = r_first;
        n_root_w = r_root_w;
        n_root_h = r_root_h;

        cell_ctl      = '0;
        cell_rd_lvl   = r_lvl;
        cell_rd_node  = r_n;
        cell_wr_lvl   = r_lvl;
        cell_wr_node  = r_n;
        cell_wr_entry = {r_mh, r_mw};
        pos_rd_en     = 1'b0;
        pos_rd_id     = i_s_tdata[ID_W-1:0];
        pos_wr_en     = 1'b0;
        pos_wr_id     = r_mh;
        pos_wr_slot   = SLOT_W'(r_n - NODE_W'(1));
        out_load      = 1'b0;

        case (r_state)
            imhpq_pkg::S_IDLE: begin
                if (s_acc) begin
                    n_op      = i_s_tuser;
                    n_id      = i_s_tdata[ID_W-1:0];
                    n_w       = i_s_tdata[ID_W +: WEIGHT_BITS];
                    n_status  = imhpq_pkg::ST_OK;
                    n_nodew   = '0;
                    n_first   = 1'b0;
                    pos_rd_en = 1'b1;
                    n_state   = imhpq_pkg::S_LOOKUP;
                end
            end

            imhpq_pkg::S_LOOKUP: begin
                n_n            = look_node;
                n_lvl          = lvl_of(look_node);
                cell_ctl.rd_en = 1'b1;
                cell_rd_lvl    = lvl_of(look_node);
                cell_rd_node   = look_node;
                n_state        = imhpq_pkg::S_CHECK;
            end

            imhpq_pkg::S_CHECK: begin
                n_state = imhpq_pkg::S_DONE;
                n_mw    = r_w;
                n_mh    = r_id;
                case (r_op)
                    imhpq_pkg::OP_INSERT: begin
                        if (present) begin
                            n_status = imhpq_pkg::ST_INVALID;
                            n_nodew  = sel_w;
                        end else if (!id_ok) begin
                            n_status = imhpq_pkg::ST_INVALID;
                        end else if (r_cnt == CNT_W'(CAPACITY)) begin
                            n_status = imhpq_pkg::ST_FULL;
                        end else begin
                            n_cnt          = r_cnt + CNT_W'(1);
                            n_nodew        = r_w;
                            n_n            = ins_node;
                            n_lvl          = lvl_of(ins_node);
                            cell_ctl.rd_en = (ins_node != NODE_W'(1));
                            cell_rd_lvl    = lvl_of(ins_node) - LVL_W'(1);
                            cell_rd_node   = ins_node >> 1;
                            n_state        = imhpq_pkg::S_UP;
                        end
                    end
                    imhpq_pkg::OP_UPDATE: begin
                        if (present) begin
                            n_nodew = r_w;
                            if (sel_w < r_w) begin
                                cell_ctl.rd_en = 1'b1;
                                cell_rd_lvl    = r_lvl + LVL_W'(1);
                                cell_rd_node   = kid_l;
                                n_state        = imhpq_pkg::S_DOWN;
                            end else if (r_w < sel_w) begin
                                cell_ctl.rd_en = (r_n != NODE_W'(1));
                                cell_rd_lvl    = r_lvl - LVL_W'(1);
                                cell_rd_node   = r_n >> 1;
                                n_state        = imhpq_pkg::S_UP;
                            end
                        end else begin
                            n_status = imhpq_pkg::ST_INVALID;
                        end
                    end
                    imhpq_pkg::OP_REMOVE: begin
                        if (present) begin
                            n_cnt = r_cnt - CNT_W'(1);
                            // removing the last slot needs no refill
                            if (r_n != cnt_ext) begin
                                cell_ctl.rd_en = 1'b1;
                                cell_rd_lvl    = lvl_of(cnt_ext);
                                cell_rd_node   = cnt_ext;
                                n_state        = imhpq_pkg::S_LAST;
                            end
                        end else begin
                            n_status = imhpq_pkg::ST_INVALID;
                        end
                    end
                    default: begin
                        if (present) begin
                            n_nodew = sel_w;
                        end else begin
                            n_status = imhpq_pkg::ST_INVALID;
                        end
                    end
                endcase
            end

            imhpq_pkg::S_LAST: begin
                n_mw           = sel_w;
                n_mh           = sel_h;
                n_first        = 1'b1;
                cell_ctl.rd_en = 1'b1;
                cell_rd_lvl    = r_lvl + LVL_W'(1);
                cell_rd_node   = kid_l;
                n_state        = imhpq_pkg::S_DOWN;
            end

            imhpq_pkg::S_DOWN: begin
                n_first = 1'b0;
                if (pick_l || pick_r) begin
                    cell_ctl.wr_en = 1'b1;
                    cell_wr_entry  = kid_ent;
                    pos_wr_en      = 1'b1;
                    pos_wr_id      = kid_ent[EW-1:WEIGHT_BITS];
                    n_n            = kid;
                    n_lvl          = r_lvl + LVL_W'(1);
                    cell_ctl.rd_en = 1'b1;
                    cell_rd_lvl    = r_lvl + LVL_W'(2);
                    cell_rd_node   = {kid[NODE_W-2:0], 1'b0};
                end else if (r_first) begin
                    // refill after a remove did not sink: try rising instead
                    cell_ctl.rd_en = (r_n != NODE_W'(1));
                    cell_rd_lvl    = r_lvl - LVL_W'(1);
                    cell_rd_node   = r_n >> 1;
                    n_state        = imhpq_pkg::S_UP;
                end else begin
                    cell_ctl.wr_en = 1'b1;
                    pos_wr_en      = 1'b1;
                    n_state        = imhpq_pkg::S_DONE;
                end
            end

            imhpq_pkg::S_UP: begin
                if ((r_n != NODE_W'(1)) && (r_mw < sel_w)) begin
                    cell_ctl.wr_en = 1'b1;
                    cell_wr_entry  = sel_ent;
                    pos_wr_en      = 1'b1;
                    pos_wr_id      = sel_h;
                    n_n            = r_n >> 1;
                    n_lvl          = r_lvl - LVL_W'(1);
                    cell_ctl.rd_en = (r_n[NODE_W-1:2] != '0);
                    cell_rd_lvl    = r_lvl - LVL_W'(2);
                    cell_rd_node   = r_n >> 2;
                end else begin
                    cell_ctl.wr_en = 1'b1;
                    pos_wr_en      = 1'b1;
                    n_state        = imhpq_pkg::S_DONE;
                end
            end

            imhpq_pkg::S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    out_load = 1'b1;
                    n_state  = imhpq_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = imhpq_pkg::S_IDLE;
            end
        endcase

        // shadow copy of the root slot
        if (cell_ctl.wr_en && (cell_wr_node == NODE_W'(1))) begin
            n_root_w = cell_wr_entry[WEIGHT_BITS-1:0];
            n_root_h = cell_wr_entry[EW-1:WEIGHT_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= imhpq_pkg::S_IDLE;
            r_cnt       <= '0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_first <= n_first;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_id     <= n_id;
        r_w      <= n_w;
        r_mw     <= n_mw;
        r_mh     <= n_mh;
        r_n      <= n_n;
        r_lvl    <= n_lvl;
        r_status <= n_status;
        r_nodew  <= n_nodew;
        r_root_w <= n_root_w;
        r_root_h <= n_root_h;
        if (out_load) begin
            r_o_status <= r_status;
            r_o_fvalid <= (r_cnt != '0);
            r_o_fid    <= (r_cnt != '0) ? r_root_h : '0;
            r_o_fw     <= (r_cnt != '0) ? r_root_w : '0;
            r_o_nw     <= r_nodew;
            r_o_cnt    <= r_cnt;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_o_status;
    assign o_m_tdata  = M_TDATA_W'({r_o_cnt, r_o_nw, r_o_fw, r_o_fid, r_o_fvalid});

    `IMHPQ_ASSERT_IMP(a_cnt_bound, 1'b1, r_cnt <= CNT_W'(CAPACITY), "count above capacity")
    `IMHPQ_ASSERT_NXT(a_acc_lookup, s_acc, r_state == imhpq_pkg::S_LOOKUP, "accept without lookup")
    `IMHPQ_ASSERT_IMP(a_walk_node, (r_state == imhpq_pkg::S_DOWN) || (r_state == imhpq_pkg::S_UP), (r_n != '0) && (r_n <= cnt_ext), "sift outside held slots")
    `IMHPQ_ASSERT_IMP(a_cnt_change, r_cnt != $past(r_cnt), $past(r_state) == imhpq_pkg::S_CHECK, "count moved outside check")

endmodule
